// ===== rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared widths, register indexes and the controller-to-datapath command
// bundle for the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Width of every value, state entry and configuration register.
  localparam int DATA_W = 32;

  // The gain carries this many fraction bits; GAIN_ONE represents one.
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // One quotient bit is produced per divider step.
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COVARIANCE = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'h0001_0000;
  localparam logic [DATA_W-1:0] MEAS_NOISE_RST = 32'h0001_0000;
  localparam logic [DATA_W-1:0] INIT_ESTIMATE_RST = 32'h0000_0000;
  localparam logic [DATA_W-1:0] INIT_COVARIANCE_RST = 32'h0001_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the measurement beat and the prior estimate
    logic predict;   // form the predicted covariance
    logic div_init;  // form the divisor and seed the divider
    logic div_step;  // produce one gain bit
    logic mul_corr;  // multiply gain by the innovation
    logic mul_cov;   // update the estimate, multiply for the covariance
    logic commit;    // update the covariance and load the output register
  } skf_cmd_t;

endpackage

// ===== rtl/skf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter controller
// Sequences one item through prediction, the gain divider, the two
// multiplications and the result register, and runs both handshakes.
// ----------------------------------------------------------------------------
module skf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output skf_pkg::skf_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRED  = 3'd1;
  localparam logic [2:0] ST_DINIT = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_MCORR = 3'd4;
  localparam logic [2:0] ST_MCOV  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic [skf_pkg::DIV_CNT_W-1:0] DIV_LAST =
    skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1);

  logic [2:0] state;
  logic [2:0] state_next;
  logic [skf_pkg::DIV_CNT_W-1:0] div_cnt;
  logic out_free;
  logic in_take;

  // The result register may be refilled when it is empty or being emptied.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && (state == ST_IDLE);

  // Commands decoded from the state.
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_take;
    cmd.predict  = (state == ST_PRED);
    cmd.div_init = (state == ST_DINIT);
    cmd.div_step = (state == ST_DIV);
    cmd.mul_corr = (state == ST_MCORR);
    cmd.mul_cov  = (state == ST_MCOV);
    cmd.commit   = (state == ST_FIN) && out_free;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PRED;
        end
      end
      ST_PRED:  state_next = ST_DINIT;
      ST_DINIT: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_LAST) begin
          state_next = ST_MCORR;
        end
      end
      ST_MCORR: state_next = ST_MCOV;
      ST_MCOV:  state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // State, divider step count and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/skf_datapath.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter datapath
// Holds the configuration registers, the estimate and covariance, a
// restoring divider for the gain, one shared multiplier and the result
// register.
// ----------------------------------------------------------------------------
module skf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]          cfg_data,
  input  logic signed [skf_pkg::DATA_W-1:0]   measurement,
  input  skf_pkg::skf_cmd_t                   cmd,
  output logic signed [skf_pkg::DATA_W-1:0]   prior_estimate,
  output logic signed [skf_pkg::DATA_W-1:0]   new_estimate,
  output logic [skf_pkg::GAIN_W-1:0]          gain
);

  localparam int DW    = skf_pkg::DATA_W;
  localparam int GW    = skf_pkg::GAIN_W;
  localparam int GB    = skf_pkg::GAIN_BITS;
  localparam int REM_W = DW + 2;
  localparam int MA_W  = GW + 1;
  localparam int MB_W  = DW + 2;
  localparam int PR_W  = MA_W + MB_W;
  localparam int CORR_W = PR_W - GB;
  localparam int SUM_W = CORR_W + 1;

  // Configuration registers. The initial values go straight into the state.
  logic [DW-1:0] process_noise;
  logic [DW-1:0] meas_noise;

  // Filter state.
  logic signed [DW-1:0] estimate;
  logic [DW-1:0]        covariance;

  // Working registers for one item.
  logic signed [DW-1:0] meas_reg;
  logic signed [DW-1:0] prior_reg;
  logic [DW-1:0]        pred_p;
  logic [DW:0]          denom;
  logic [REM_W-1:0]     rem;
  logic [GW-1:0]        quot;
  logic [GW-1:0]        gain_reg;
  logic signed [PR_W-1:0] prod;

  logic [DW:0]          pred_sum;
  logic [DW-1:0]        pred_sat;
  logic [DW:0]          denom_sum;
  logic                 rem_ge;
  logic [REM_W-1:0]     rem_sub;
  logic [REM_W-1:0]     rem_kept;
  logic [GW-1:0]        k_eff;
  logic signed [DW:0]   innov;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] mul_p;
  logic signed [CORR_W-1:0] corr;
  logic signed [SUM_W-1:0]  est_sum;
  logic signed [DW-1:0]     est_sat;
  logic [GW-1:0]        one_minus_k;

  // Prediction: covariance plus process noise, held at the top of the range.
  assign pred_sum = {1'b0, covariance} + {1'b0, process_noise};
  assign pred_sat = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
  assign denom_sum = {1'b0, pred_p} + {1'b0, meas_noise};

  // Restoring divider step: one quotient bit per cycle.
  assign rem_ge   = (rem >= {1'b0, denom});
  assign rem_sub  = rem - {1'b0, denom};
  assign rem_kept = rem_ge ? rem_sub : rem;

  // A zero divisor yields a zero gain.
  assign k_eff = (denom == '0) ? '0 : quot;
  assign one_minus_k = skf_pkg::GAIN_ONE - gain_reg;

  // Innovation y - x, one bit wider than its operands.
  assign innov = {meas_reg[DW-1], meas_reg} - {prior_reg[DW-1], prior_reg};

  // Shared multiplier operands.
  always_comb begin
    if (cmd.mul_cov) begin
      mul_a = {1'b0, one_minus_k};
      mul_b = {2'b00, pred_p};
    end else begin
      mul_a = {1'b0, k_eff};
      mul_b = {innov[DW], innov};
    end
  end
  assign mul_p = mul_a * mul_b;

  // Correction rounded toward minus infinity, then the saturated sum.
  assign corr    = prod[PR_W-1:GB];
  assign est_sum = {{(SUM_W-DW){prior_reg[DW-1]}}, prior_reg} + {corr[CORR_W-1], corr};
  always_comb begin
    if (est_sum[SUM_W-1:DW-1] == '0 || est_sum[SUM_W-1:DW-1] == '1) begin
      est_sat = est_sum[DW-1:0];
    end else if (est_sum[SUM_W-1]) begin
      est_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      est_sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // Configuration registers and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise   <= skf_pkg::PROCESS_NOISE_RST;
      meas_noise      <= skf_pkg::MEAS_NOISE_RST;
      estimate        <= skf_pkg::INIT_ESTIMATE_RST;
      covariance      <= skf_pkg::INIT_COVARIANCE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          skf_pkg::REG_PROCESS_NOISE:   process_noise <= cfg_data;
          skf_pkg::REG_MEAS_NOISE:      meas_noise    <= cfg_data;
          skf_pkg::REG_INIT_ESTIMATE:   estimate      <= cfg_data;
          skf_pkg::REG_INIT_COVARIANCE: covariance    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.mul_cov) begin
        estimate <= est_sat;
      end
      if (cmd.commit) begin
        // The product is below 2^48, so the shifted value fits 32 bits.
        covariance <= prod[GB+DW-1:GB];
      end
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas_reg  <= measurement;
      prior_reg <= estimate;
    end
    if (cmd.predict) begin
      pred_p <= pred_sat;
    end
    if (cmd.div_init) begin
      denom <= denom_sum;
      rem   <= {2'b00, pred_p};
      quot  <= '0;
    end
    if (cmd.div_step) begin
      rem  <= {rem_kept[REM_W-2:0], 1'b0};
      quot <= {quot[GW-2:0], rem_ge};
    end
    if (cmd.mul_corr) begin
      gain_reg <= k_eff;
      prod     <= mul_p;
    end
    if (cmd.mul_cov) begin
      prod <= mul_p;
    end
    if (cmd.commit) begin
      prior_estimate <= prior_reg;
      new_estimate   <= estimate;
      gain           <= gain_reg;
    end
  end

endmodule

// ===== rtl/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// One-dimensional random-walk Kalman filter in fixed point: one measurement
// beat in, one beat of prior estimate, new estimate and gain out.
// ----------------------------------------------------------------------------
// Sequence: an accepted measurement beat passes through prediction, the 17
// steps of the restoring gain divider and the two multiplications.
// A new measurement is taken only once the previous result is committed;
// a finished result waits in the output register while the next is taken.
// Reset: configuration registers return to their defaults, the estimate to
// zero and the covariance to one; there is no clearing pass.
module scalar_kalman_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [skf_pkg::DATA_W-1:0] measurement,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [skf_pkg::DATA_W-1:0] prior_estimate,
  output logic signed [skf_pkg::DATA_W-1:0] new_estimate,
  output logic [skf_pkg::GAIN_W-1:0]        gain
);

  skf_pkg::skf_cmd_t cmd;

  // Sequencing and handshakes.
  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic, state and result register.
  skf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .measurement    (measurement),
    .cmd            (cmd),
    .prior_estimate (prior_estimate),
    .new_estimate   (new_estimate),
    .gain           (gain)
  );

endmodule

// ===== tb/sv/scalar_kalman_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives measurement beats through the filter under random idling on both
// sides and checks every result beat against a fixed-point prediction of
// the random-walk update. A short directed run covers the value extremes, a
// zero gain denominator, a gain of one and saturated prediction, then
// randomised phases reprogramme the noise and initial state registers.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_tb;

  localparam int ITEMS_PER_PHASE = 108;
  localparam int RANDOM_PHASES = 12;
  localparam int SETTLE_CYCLES = 30;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT = 10;

  // One result beat as the filter should produce it.
  typedef struct {
    logic signed [skf_pkg::DATA_W-1:0] prior;
    logic signed [skf_pkg::DATA_W-1:0] updated;
    logic [skf_pkg::GAIN_W-1:0]        gain;
  } filter_result_t;

  // Tracks the filter state, predicts each update and checks result beats.
  class kalman_checker;
    logic signed [skf_pkg::DATA_W-1:0] estimate;
    logic [skf_pkg::DATA_W-1:0]        covariance;
    logic [skf_pkg::DATA_W-1:0]        q_var;
    logic [skf_pkg::DATA_W-1:0]        r_var;
    filter_result_t                    expected_q[$];
    int                                mismatches;

    function new();
      q_var = skf_pkg::PROCESS_NOISE_RST;
      r_var = skf_pkg::MEAS_NOISE_RST;
      estimate = skf_pkg::INIT_ESTIMATE_RST;
      covariance = skf_pkg::INIT_COVARIANCE_RST;
      mismatches = 0;
    endfunction

    // Loading an initial value also replaces the live state at once.
    function void write_reg(logic [skf_pkg::CFG_IDX_W-1:0] idx,
                            logic [skf_pkg::DATA_W-1:0] val);
      case (idx)
        skf_pkg::REG_PROCESS_NOISE: q_var = val;
        skf_pkg::REG_MEAS_NOISE: r_var = val;
        skf_pkg::REG_INIT_ESTIMATE: estimate = val;
        skf_pkg::REG_INIT_COVARIANCE: covariance = val;
        default: ;
      endcase
    endfunction

    // Predict, form the gain, then update estimate and covariance.
    function void note_measurement(logic signed [skf_pkg::DATA_W-1:0] y);
      longint unsigned pred_p;
      longint unsigned denom;
      longint unsigned k;
      longint unsigned np;
      longint          y_wide;
      longint          prior_wide;
      longint          corr;
      longint          nx;
      filter_result_t  res;
      pred_p = longint'(covariance) + longint'(q_var);
      if (pred_p > 64'hFFFF_FFFF) pred_p = 64'hFFFF_FFFF;
      denom = pred_p + longint'(r_var);
      k = (denom == 0) ? 0 : (pred_p << skf_pkg::GAIN_BITS) / denom;
      if (k > longint'(skf_pkg::GAIN_ONE)) k = longint'(skf_pkg::GAIN_ONE);
      y_wide = y;
      prior_wide = estimate;
      // Arithmetic shift of the signed product rounds toward minus infinity.
      corr = (longint'(k) * (y_wide - prior_wide)) >>> skf_pkg::GAIN_BITS;
      nx = prior_wide + corr;
      if (nx > 64'sd2147483647) nx = 64'sd2147483647;
      if (nx < -64'sd2147483648) nx = -64'sd2147483648;
      np = ((longint'(skf_pkg::GAIN_ONE) - k) * pred_p) >> skf_pkg::GAIN_BITS;
      if (np > 64'hFFFF_FFFF) np = 64'hFFFF_FFFF;
      res.prior = estimate;
      res.updated = nx[skf_pkg::DATA_W-1:0];
      res.gain = k[skf_pkg::GAIN_W-1:0];
      estimate = nx[skf_pkg::DATA_W-1:0];
      covariance = np[skf_pkg::DATA_W-1:0];
      expected_q.push_back(res);
    endfunction

    function void report(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_result(logic signed [skf_pkg::DATA_W-1:0] prior,
                               logic signed [skf_pkg::DATA_W-1:0] updated,
                               logic [skf_pkg::GAIN_W-1:0] g);
      filter_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result beat, prior estimate", 0, prior);
        return;
      end
      want = expected_q.pop_front();
      if (prior !== want.prior) report("prior estimate", want.prior, prior);
      if (updated !== want.updated) report("new estimate", want.updated, updated);
      if (g !== want.gain) report("gain", want.gain, g);
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [skf_pkg::DATA_W-1:0]        cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [skf_pkg::DATA_W-1:0] measurement;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [skf_pkg::DATA_W-1:0] prior_estimate;
  logic signed [skf_pkg::DATA_W-1:0] new_estimate;
  logic [skf_pkg::GAIN_W-1:0]        gain;

  // Idling controls shared between the sending and receiving processes.
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold_req;

  kalman_checker chk = new();

  scalar_kalman_filter dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .measurement(measurement),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .prior_estimate(prior_estimate),
    .new_estimate(new_estimate),
    .gain(gain)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register writes and beats on both channels, sampled at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) chk.write_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) chk.check_result(prior_estimate, new_estimate, gain);
      if (in_valid && !in_stall) chk.note_measurement(measurement);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int burst;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run when no beat or register write has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [skf_pkg::DATA_W-1:0] pick_extreme(int i);
    case (i % 6)
      0: return 32'sh0000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return 32'sh0001_0000;
    endcase
  endfunction

  // Mostly noisy samples around a centre so that the filter settles, with
  // full-range values and extremes mixed in.
  function automatic logic signed [skf_pkg::DATA_W-1:0] random_measurement(
      logic signed [skf_pkg::DATA_W-1:0] centre);
    logic signed [skf_pkg::DATA_W-1:0] noise;
    noise = $signed($urandom) >>> $urandom_range(4, 30);
    case ($urandom_range(0, 9))
      0: return pick_extreme($urandom_range(0, 5));
      1, 2: return $signed($urandom);
      default: return centre + noise;
    endcase
  endfunction

  // Noise and covariance values: zero, full scale, small, or any.
  function automatic logic [skf_pkg::DATA_W-1:0] random_variance();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      3: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // Writes the registers whose bit is set in the mask, one per cycle.
  task automatic program_filter(logic [3:0] mask, logic [skf_pkg::DATA_W-1:0] q,
                                logic [skf_pkg::DATA_W-1:0] r,
                                logic [skf_pkg::DATA_W-1:0] x0,
                                logic [skf_pkg::DATA_W-1:0] p0);
    logic [skf_pkg::DATA_W-1:0] vals[4];
    vals[skf_pkg::REG_PROCESS_NOISE] = q;
    vals[skf_pkg::REG_MEAS_NOISE] = r;
    vals[skf_pkg::REG_INIT_ESTIMATE] = x0;
    vals[skf_pkg::REG_INIT_COVARIANCE] = p0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we <= 1'b1;
        cfg_index <= skf_pkg::CFG_IDX_W'(i);
        cfg_data <= vals[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one measurement beat, after an optional gap, until accepted.
  task automatic send_measurement(logic signed [skf_pkg::DATA_W-1:0] value);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    measurement <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every predicted result has been checked, then settles.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic signed [skf_pkg::DATA_W-1:0] centre;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    measurement <= '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    long_hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default registers: every extreme of the measurement.
    for (int i = 0; i < 9; i++) send_measurement(pick_extreme(i));
    drain_results();

    // Zero noise and zero covariance: the denominator is zero, gain zero.
    program_filter(4'hF, 32'h0, 32'h0, 32'h1234_5678, 32'h0);
    for (int i = 0; i < 3; i++) send_measurement(pick_extreme(i + 1));
    drain_results();

    // Full-scale process noise and covariance: prediction saturates, gain near one.
    program_filter(4'hF, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_measurement(pick_extreme(i));
    drain_results();

    // Huge measurement noise: the gain rounds to zero.
    program_filter(4'hF, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1);
    for (int i = 0; i < 3; i++) send_measurement(pick_extreme(i + 2));
    drain_results();

    // No measurement noise: the gain is exactly one.
    program_filter(4'hF, 32'h5, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 3; i++) send_measurement(pick_extreme(i + 1));
    drain_results();

    // Random settings; one phase runs without idling and one holds the
    // receiver off while beats keep coming. The last phase has no idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      tx_idle_on = (ph != RANDOM_PHASES - 1) && (ph != 5);
      rx_idle_on = (ph != RANDOM_PHASES - 1) && (ph != 5);
      centre = $signed($urandom);
      program_filter((ph == 0) ? 4'hF : 4'($urandom_range(1, 15)), random_variance(),
                     random_variance(), $urandom, random_variance());
      if (ph == 3) long_hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_measurement(random_measurement(centre));
      drain_results();
    end

    if (chk.mismatches == 0 && chk.expected_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
